@@ design/pts_pkg.sv @@
// Package for the periodic task scheduler: field widths, codes and the
// control/status structs passed between the sequencer and the slot ALU.
// No dependencies.
package pts_pkg;

  // Default sizing handed to the top-level parameters
  localparam int MAX_TASKS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths
  localparam int EXEC_W     = 16;  // exec time, period, relative deadline
  localparam int SLOT_W     = 4;   // task_index field
  localparam int ID_W       = 5;   // task_id result
  localparam int DL_OUT_W   = 17;  // job_deadline result
  localparam int TICK_W     = 16;  // tick_time result
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int TCNT_W     = 5;

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Policy codes
  localparam logic POLICY_RM  = 1'b0;
  localparam logic POLICY_EDF = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 2'd1;

  // Sequencer to slot ALU
  typedef struct packed {
    logic policy;      // selects the key
    logic in_range;    // slot takes part in this tick
    logic wrap;        // time wraps after this tick: rebase on write-back
    logic best_found;  // a candidate is already held
  } pts_ctl_t;

  // Slot ALU to sequencer
  typedef struct packed {
    logic take;        // slot beats the held candidate
  } pts_sts_t;

endpackage

@@ design/pts_slot_alu.sv @@
// Shared per-slot datapath of the scheduler: release update, key compare
// and post-wrap rebase for the one slot under the sequencer.
// Depends on pts_pkg.
module pts_slot_alu #(
  parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
  input  pts_pkg::pts_ctl_t                   ctl_i,
  input  logic [TIME_BITS-1:0]                now_i,
  input  logic [((TIME_BITS+1 > pts_pkg::EXEC_W) ?
                 TIME_BITS+1 : pts_pkg::EXEC_W)-1:0] best_key_i,
  input  logic [pts_pkg::EXEC_W-1:0]          rem_i,
  input  logic [TIME_BITS:0]                  nr_i,
  input  logic [TIME_BITS:0]                  dl_i,
  input  logic [pts_pkg::EXEC_W-1:0]          exec_i,
  input  logic [pts_pkg::EXEC_W-1:0]          period_i,
  input  logic [pts_pkg::EXEC_W-1:0]          reldl_i,
  output logic [pts_pkg::EXEC_W-1:0]          rem_o,
  output logic [TIME_BITS:0]                  dl_o,
  output logic [TIME_BITS:0]                  nr_wb_o,
  output logic [TIME_BITS:0]                  dl_wb_o,
  output logic [((TIME_BITS+1 > pts_pkg::EXEC_W) ?
                 TIME_BITS+1 : pts_pkg::EXEC_W)-1:0] key_o,
  output pts_pkg::pts_sts_t                   sts_o
);

  localparam int WideW = TIME_BITS + 1;
  localparam int KeyW  = (WideW > pts_pkg::EXEC_W) ? WideW : pts_pkg::EXEC_W;

  logic             rel;
  logic [WideW-1:0] now_w;
  logic [WideW-1:0] nr_next;

  assign now_w = {1'b0, now_i};
  assign rel   = ctl_i.in_range && (nr_i == now_w);

  // release: sums kept modulo 2^WideW
  assign rem_o   = rel ? exec_i : rem_i;
  assign dl_o    = rel ? (now_w + WideW'(reldl_i)) : dl_i;
  assign nr_next = rel ? (nr_i + WideW'(period_i)) : nr_i;

  assign key_o = (ctl_i.policy == pts_pkg::POLICY_EDF) ? KeyW'(dl_o) : KeyW'(period_i);

  // strict less-than keeps ties on the lowest slot (ascending walk)
  assign sts_o.take = ctl_i.in_range && (rem_o != '0) &&
                      (!ctl_i.best_found || (key_o < best_key_i));

  // rebase on wrap: drop 2^TIME_BITS; past deadlines go to 0
  assign nr_wb_o = ctl_i.wrap ? {1'b0, nr_next[TIME_BITS-1:0]} : nr_next;
  assign dl_wb_o = ctl_i.wrap ? (dl_o[TIME_BITS] ? {1'b0, dl_o[TIME_BITS-1:0]} : '0)
                              : dl_o;

endmodule

@@ design/pts_task_mem.sv @@
// Task slot storage: static table (exec, period, relative deadline) and
// dynamic state (remaining work, next release, deadline) with valid bits.
// Depends on pts_pkg.
module pts_task_mem #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   stat_we_i,
  input  logic                                   dyn_we_i,
  input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] wr_addr_i,
  input  logic [3*pts_pkg::EXEC_W-1:0]           stat_wdata_i,
  input  logic [pts_pkg::EXEC_W+2*(TIME_BITS+1)-1:0] dyn_wdata_i,
  input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] rd_addr_i,
  output logic [3*pts_pkg::EXEC_W-1:0]           stat_rdata_o,
  output logic [pts_pkg::EXEC_W+2*(TIME_BITS+1)-1:0] dyn_rdata_o
);

  localparam int StatW = 3 * pts_pkg::EXEC_W;
  localparam int DynW  = pts_pkg::EXEC_W + 2 * (TIME_BITS + 1);

  logic [StatW-1:0]     stat_mem [MAX_TASKS];
  logic [DynW-1:0]      dyn_mem  [MAX_TASKS];
  logic [MAX_TASKS-1:0] dyn_vld_q;
  logic [DynW-1:0]      dyn_raw_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (stat_we_i) begin
      stat_mem[wr_addr_i] <= stat_wdata_i;
    end
    if (dyn_we_i) begin
      dyn_mem[wr_addr_i] <= dyn_wdata_i;
    end
    stat_rdata_o <= stat_mem[rd_addr_i];
    dyn_raw_q    <= dyn_mem[rd_addr_i];
  end

  // unwritten dynamic entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (dyn_we_i) begin
        dyn_vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= dyn_vld_q[rd_addr_i];
    end
  end

  assign dyn_rdata_o = rd_vld_q ? dyn_raw_q : '0;

endmodule

@@ design/periodic_task_scheduler_unit.sv @@
// Periodic task scheduler top level: item handshake, sequencer over task
// slots, output register and config registers.
// Depends on pts_pkg, pts_task_mem and pts_slot_alu.

// A load item (mode 0) writes the slot's execution time, period and
// relative deadline, clears its remaining work, next release and
// deadline, and restarts time at 0; a slot index not below MAX_TASKS is
// dropped. A tick item (mode 1) is accepted while slot 0 is read, then
// walks one slot a cycle through the single slot ALU and the one memory
// port pair (release, key compare, write-back, rebase when time wraps),
// then writes back the chosen slot's remaining work. The tick yields one
// result item: idle, or the task id (slot plus one) and its absolute
// deadline, with the tick time. Every slot is walked on every tick,
// whatever task_count says, so the rebase on a time wrap reaches them
// all. Ties go to the lowest slot. A finished result waits in an output
// register, and the next item is taken meanwhile. Dynamic state clears at
// reset through per-slot valid bits, so there is no clearing pass. Config
// writes are always ready and must only come while the block is idle.
module periodic_task_scheduler_unit #(
  parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF,
  parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [pts_pkg::SLOT_W-1:0]        task_index_i,
  input  logic [pts_pkg::EXEC_W-1:0]        exec_time_i,
  input  logic [pts_pkg::EXEC_W-1:0]        task_period_i,
  input  logic [pts_pkg::EXEC_W-1:0]        relative_deadline_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              idle_o,
  output logic [pts_pkg::ID_W-1:0]          task_id_o,
  output logic [pts_pkg::DL_OUT_W-1:0]      job_deadline_o,
  output logic [pts_pkg::TICK_W-1:0]        tick_time_o,
  // config writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int IdxW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CntW  = $clog2(MAX_TASKS + 1);
  localparam int WideW = TIME_BITS + 1;
  localparam int KeyW  = (WideW > pts_pkg::EXEC_W) ? WideW : pts_pkg::EXEC_W;
  localparam int ExW   = pts_pkg::EXEC_W;
  localparam int StatW = 3 * ExW;
  localparam int DynW  = ExW + 2 * WideW;
  localparam int IdW   = pts_pkg::ID_W;
  localparam int DlW   = pts_pkg::DL_OUT_W;
  localparam int TickW = pts_pkg::TICK_W;

  localparam logic [IdxW-1:0] LastSlot = IdxW'(MAX_TASKS - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // ready for an item
  localparam logic [1:0] S_SCAN = 2'd1;  // one slot per cycle
  localparam logic [1:0] S_WB   = 2'd2;  // charge the chosen slot, emit
  localparam logic [1:0] S_EMIT = 2'd3;  // wait for the output register

  logic [1:0]                   state_q, state_d;
  logic [IdxW-1:0]              proc_idx_q, proc_idx_d;
  logic [TIME_BITS-1:0]         now_q, now_d;
  logic                         policy_q;
  logic [pts_pkg::TCNT_W-1:0]   task_count_q;

  logic                         best_found_q, best_found_d;
  logic [KeyW-1:0]              best_key_q;
  logic [IdxW-1:0]              best_idx_q;
  logic [ExW-1:0]               best_rem_q;
  logic [WideW-1:0]             best_dl_q;
  logic [WideW-1:0]             best_nr_wb_q;
  logic [WideW-1:0]             best_dl_wb_q;

  logic                         out_valid_q, out_valid_d;
  logic                         idle_q;
  logic [IdW-1:0]               task_id_q;
  logic [DlW-1:0]               job_dl_q;
  logic [TickW-1:0]             tick_q;

  logic                         in_acc, ld_ok, tick_go, out_free, out_load;
  logic [CntW-1:0]              active;

  // memory ports
  logic                         stat_we, dyn_we;
  logic [IdxW-1:0]              wr_addr, rd_addr;
  logic [StatW-1:0]             stat_wdata, stat_rdata;
  logic [DynW-1:0]              dyn_wdata, dyn_rdata;

  // slot ALU
  pts_pkg::pts_ctl_t            alu_ctl;
  pts_pkg::pts_sts_t            alu_sts;
  logic [ExW-1:0]               alu_rem;
  logic [WideW-1:0]             alu_dl, alu_nr_wb, alu_dl_wb;
  logic [KeyW-1:0]              alu_key;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign ld_ok    = in_acc && (mode_i == pts_pkg::MODE_LOAD) &&
                    (int'(task_index_i) < MAX_TASKS);
  assign tick_go  = in_acc && (mode_i == pts_pkg::MODE_TICK);
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = ((state_q == S_WB) || (state_q == S_EMIT)) && out_free;

  // slots at or above task_count (saturated) sit out
  assign active = (int'(task_count_q) > MAX_TASKS) ? CntW'(MAX_TASKS) : CntW'(task_count_q);

  // --------------------------------------------------------------------------
  // Storage
  // --------------------------------------------------------------------------
  assign stat_we    = ld_ok;
  assign dyn_we     = ld_ok || (state_q == S_SCAN) || ((state_q == S_WB) && best_found_q);
  assign stat_wdata = {exec_time_i, task_period_i, relative_deadline_i};

  always_comb begin
    if (ld_ok) begin
      wr_addr   = IdxW'(task_index_i);
      dyn_wdata = '0;
    end else if (state_q == S_SCAN) begin
      wr_addr   = proc_idx_q;
      dyn_wdata = {alu_rem, alu_nr_wb, alu_dl_wb};
    end else begin
      wr_addr   = best_idx_q;
      dyn_wdata = {best_rem_q - ExW'(1), best_nr_wb_q, best_dl_wb_q};
    end
  end

  // read one slot ahead of the one being processed
  assign rd_addr = ((state_q == S_SCAN) && (proc_idx_q != LastSlot)) ?
                   proc_idx_q + IdxW'(1) : '0;

  pts_task_mem #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_mem (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stat_we_i    (stat_we),
    .dyn_we_i     (dyn_we),
    .wr_addr_i    (wr_addr),
    .stat_wdata_i (stat_wdata),
    .dyn_wdata_i  (dyn_wdata),
    .rd_addr_i    (rd_addr),
    .stat_rdata_o (stat_rdata),
    .dyn_rdata_o  (dyn_rdata)
  );

  // --------------------------------------------------------------------------
  // Slot ALU
  // --------------------------------------------------------------------------
  assign alu_ctl.policy     = policy_q;
  assign alu_ctl.in_range   = (CntW'(proc_idx_q) < active);
  assign alu_ctl.wrap       = &now_q;
  assign alu_ctl.best_found = best_found_q;

  pts_slot_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .ctl_i      (alu_ctl),
    .now_i      (now_q),
    .best_key_i (best_key_q),
    .rem_i      (dyn_rdata[DynW-1 -: ExW]),
    .nr_i       (dyn_rdata[2*WideW-1 -: WideW]),
    .dl_i       (dyn_rdata[WideW-1:0]),
    .exec_i     (stat_rdata[StatW-1 -: ExW]),
    .period_i   (stat_rdata[2*ExW-1 -: ExW]),
    .reldl_i    (stat_rdata[ExW-1:0]),
    .rem_o      (alu_rem),
    .dl_o       (alu_dl),
    .nr_wb_o    (alu_nr_wb),
    .dl_wb_o    (alu_dl_wb),
    .key_o      (alu_key),
    .sts_o      (alu_sts)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    proc_idx_d   = proc_idx_q;
    now_d        = now_q;
    best_found_d = best_found_q;
    unique case (state_q)
      S_IDLE: begin
        if (ld_ok) begin
          now_d = '0;
        end else if (tick_go) begin
          state_d      = S_SCAN;
          proc_idx_d   = '0;
          best_found_d = 1'b0;
        end
      end
      S_SCAN: begin
        if (alu_sts.take) begin
          best_found_d = 1'b1;
        end
        if (proc_idx_q == LastSlot) begin
          state_d = S_WB;
        end else begin
          proc_idx_d = proc_idx_q + IdxW'(1);
        end
      end
      S_WB: begin
        now_d   = now_q + TIME_BITS'(1);
        state_d = out_free ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      proc_idx_q   <= '0;
      now_q        <= '0;
      best_found_q <= 1'b0;
      policy_q     <= pts_pkg::POLICY_RM;
      task_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      proc_idx_q   <= proc_idx_d;
      now_q        <= now_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          pts_pkg::REG_POLICY:     policy_q     <= cfg_data_i[0];
          pts_pkg::REG_TASK_COUNT: task_count_q <= cfg_data_i[pts_pkg::TCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // candidate capture: pre-rebase deadline for the report, rebased for write-back
  always_ff @(posedge clk_i) begin
    if ((state_q == S_SCAN) && alu_sts.take) begin
      best_key_q   <= alu_key;
      best_idx_q   <= proc_idx_q;
      best_rem_q   <= alu_rem;
      best_dl_q    <= alu_dl;
      best_nr_wb_q <= alu_nr_wb;
      best_dl_wb_q <= alu_dl_wb;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // now_q has advanced by one when the load comes from S_EMIT
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      idle_q    <= !best_found_q;
      task_id_q <= best_found_q ? IdW'({1'b0, best_idx_q} + (IdxW + 1)'(1)) : '0;
      job_dl_q  <= best_found_q ? DlW'(best_dl_q) : '0;
      tick_q    <= (state_q == S_WB) ? TickW'(now_q) : TickW'(now_q - TIME_BITS'(1));
    end
  end

  assign out_valid_o    = out_valid_q;
  assign idle_o         = idle_q;
  assign task_id_o      = task_id_q;
  assign job_deadline_o = job_dl_q;
  assign tick_time_o    = tick_q;

`ifndef SYNTHESIS
  // a result appears only from the write-back or wait states
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_WB) || ($past(state_q) == S_EMIT))
    else $error("result raised outside write-back");

  // idle and a zero task id go together
  a_idle_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idle_o == (task_id_o == '0)))
    else $error("idle flag and task id disagree");

  // a tick starts the walk at slot 0
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_go |=> (state_q == S_SCAN) && (proc_idx_q == '0))
    else $error("tick did not start the slot walk");

  // the walk ends after the last slot
  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && (proc_idx_q == LastSlot) |=> (state_q == S_WB))
    else $error("slot walk overran");
`endif

endmodule
